// ===== hw/rtl/flha_pkg.sv =====
// ----------------------------------------------------------------------------
// flha_pkg: shared types and constants of the free-list heap allocator.
// Holds the item layouts, the segment table entry and the status codes.
// ----------------------------------------------------------------------------
package flha_pkg;

    localparam int FREE_SLOTS = 64;
    localparam int SLOT_W     = 6;
    localparam int NODE_W     = 7;
    localparam int UNITS_W    = 17;
    localparam int ADDR_W     = 16;
    localparam int BYTES_W    = 20;

    // Node index that stands for the list head, and the empty-list mark.
    localparam logic [NODE_W-1:0]  HEAD_NODE  = 7'd64;
    localparam logic [NODE_W-1:0]  WALK_LIMIT = 7'd64;
    localparam logic [UNITS_W-1:0] HEAP_UNITS = 17'h10000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BAD     = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] CFG_FIT_POLICY  = 2'd0;
    localparam logic [1:0] CFG_SEARCH_ROVE = 2'd1;
    localparam logic [1:0] CFG_COALESCING  = 2'd2;

    typedef struct packed {
        logic               action;
        logic [BYTES_W-1:0] request_bytes;
        logic [ADDR_W-1:0]  block_address;
        logic [UNITS_W-1:0] block_units;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  granted_address;
        logic [UNITS_W-1:0] granted_units;
    } rsp_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [UNITS_W-1:0] units;
        logic [NODE_W-1:0]  link;
    } seg_t;

    typedef struct packed {
        logic              set;
        logic [SLOT_W-1:0] set_idx;
        logic              clr;
        logic [SLOT_W-1:0] clr_idx;
    } slot_ctrl_t;

    typedef struct packed {
        logic              any;
        logic [SLOT_W-1:0] idx;
    } slot_stat_t;

endpackage

// ===== hw/rtl/flha_slot_pool.sv =====
// ----------------------------------------------------------------------------
// flha_slot_pool: occupancy of the segment table slots.
// Keeps one in-use bit per slot and a registered lowest free slot.
// ----------------------------------------------------------------------------
module flha_slot_pool
    import flha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_ctrl_t ctrl,
    output slot_stat_t stat
);

    logic [FREE_SLOTS-1:0] used_reg;
    logic [FREE_SLOTS-1:0] used_next;
    slot_stat_t            stat_reg;
    slot_stat_t            stat_next;

    always_comb
    begin
        used_next = used_reg;
        if (ctrl.clr)
        begin
            used_next[ctrl.clr_idx] = 1'b0;
        end
        if (ctrl.set)
        begin
            used_next[ctrl.set_idx] = 1'b1;
        end
    end

    // The free slot is registered from the bits and so lags them; no item uses it that soon.
    always_comb
    begin
        stat_next = '0;
        for (int i = FREE_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                stat_next.any = 1'b1;
                stat_next.idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            stat_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

    a_set_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.set |-> !used_reg[ctrl.set_idx])
        else $error("slot taken that is already in use");

endmodule

// ===== hw/rtl/free_list_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_heap_allocator: heap allocator over 16-byte units.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req (req_item_t)
//   rsp      out        rsp_valid/rsp_stall rsp (rsp_item_t)
//   cfg      in         cfg_we              cfg_index, cfg_data
//
// Each list node visited costs one read of the segment table memory and one
// evaluation step. An allocate that unlinks a segment, or grows the heap with
// coalescing on, walks the list a second time to find the predecessor.
// After reset the list is empty and no clearing pass is needed.
// req_stall is high while an item is in work; a waiting result does not
// block the next item until that item finishes.
// ----------------------------------------------------------------------------
module free_list_heap_allocator
    import flha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_item_t  req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_item_t  rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_A_RD  = 14'b00000000000010,
        S_A_EV  = 14'b00000000000100,
        S_A_DEC = 14'b00000000001000,
        S_P_RD  = 14'b00000000010000,
        S_P_EV  = 14'b00000000100000,
        S_N_RD  = 14'b00000001000000,
        S_N_EV  = 14'b00000010000000,
        S_DISP  = 14'b00000100000000,
        S_LINK  = 14'b00001000000000,
        S_C_RD  = 14'b00010000000000,
        S_C_EV  = 14'b00100000000000,
        S_C_DEC = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        PUR_EXACT = 2'd0,
        PUR_GROW  = 2'd1,
        PUR_FREE  = 2'd2
    } purpose_t;

    // Segment table memory.
    seg_t              seg_mem [FREE_SLOTS];
    seg_t              mem_rdata;
    logic              mem_re;
    logic [SLOT_W-1:0] mem_raddr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    seg_t              mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_rdata <= seg_mem[mem_raddr];
        end
        if (mem_we)
        begin
            seg_mem[mem_waddr] <= mem_wdata;
        end
    end

    slot_ctrl_t slot_ctrl;
    slot_stat_t slot_stat;

    flha_slot_pool u_pool (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (slot_ctrl),
        .stat (slot_stat)
    );

    state_t             state_reg,   state_next;
    purpose_t           pur_reg,     pur_next;
    logic [1:0]         fit_reg,     fit_next;
    logic               rove_reg,    rove_next;
    logic               coal_reg,    coal_next;
    logic [NODE_W-1:0]  head_reg,    head_next;
    logic [NODE_W-1:0]  rover_reg,   rover_next;
    logic [UNITS_W-1:0] top_reg,     top_next;
    logic [UNITS_W-1:0] need_reg,    need_next;
    logic [UNITS_W-1:0] grow_reg,    grow_next;
    logic [NODE_W-1:0]  start_reg,   start_next;
    logic [NODE_W-1:0]  cur_reg,     cur_next;
    logic [NODE_W-1:0]  cnt_reg,     cnt_next;
    logic               found_reg,   found_next;
    logic [UNITS_W-1:0] best_reg,    best_next;
    logic [NODE_W-1:0]  pick_reg,    pick_next;
    seg_t               pdat_reg,    pdat_next;
    logic [NODE_W-1:0]  p_reg,       p_next;
    seg_t               pd_reg,      pd_next;
    logic [NODE_W-1:0]  target_reg,  target_next;
    logic [SLOT_W-1:0]  s_reg,       s_next;
    logic [ADDR_W-1:0]  h_reg,       h_next;
    logic [UNITS_W-1:0] bu_reg,      bu_next;
    logic [NODE_W-1:0]  f_reg,       f_next;
    seg_t               fd_reg,      fd_next;
    logic [NODE_W-1:0]  nx_reg,      nx_next;
    seg_t               nxd_reg,     nxd_next;
    rsp_item_t          res_reg,     res_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_item_t          rsp_reg,     rsp_next;

    // Request decode.
    logic [UNITS_W-1:0] req_need;
    logic               req_free_bad;
    assign req_need = UNITS_W'(({1'b0, req.request_bytes} + 21'd15) >> 4) + 17'd1;
    assign req_free_bad = (req.block_address == '0) || (req.block_units == '0) ||
        (({2'b0, req.block_address} - 18'd1 + {1'b0, req.block_units}) >
         {1'b0, top_reg});

    // Walk evaluation.
    logic [UNITS_W-1:0] walk_u;
    logic [NODE_W-1:0]  walk_nxt;
    logic               take;
    logic               is_best, is_worst;
    assign walk_u   = (cur_reg == HEAD_NODE) ? '0 : mem_rdata.units;
    assign walk_nxt = (cur_reg == HEAD_NODE) ? head_reg : mem_rdata.link;
    assign is_best  = (fit_reg == FIT_BEST);
    assign is_worst = (fit_reg == FIT_WORST);

    always_comb
    begin
        case (fit_reg)
            FIT_BEST:  take = (walk_u >= need_reg) && (!found_reg || walk_u < best_reg);
            FIT_WORST: take = (walk_u > best_reg);
            default:   take = (walk_u >= need_reg);
        endcase
    end

    // Heap growth in whole pages.
    logic [UNITS_W:0]   grow_sum;
    logic [UNITS_W-1:0] grow_w;
    logic               grow_fits;
    assign grow_sum  = {1'b0, need_reg} + 18'd255;
    assign grow_w    = {grow_sum[UNITS_W-1:8], 8'b0};
    assign grow_fits = ({1'b0, grow_w} + {1'b0, top_reg}) <= {1'b0, HEAP_UNITS};

    logic [NODE_W-1:0]  p_link;
    logic [NODE_W-1:0]  pev_next;
    assign p_link   = (p_reg == HEAD_NODE) ? head_reg : pd_reg.link;
    assign pev_next = (p_reg == HEAD_NODE) ? head_reg : mem_rdata.link;

    logic join_next, join_prev;
    assign join_next = (nx_reg != HEAD_NODE) &&
        (({2'b0, h_reg} + {1'b0, bu_reg}) == {2'b0, nxd_reg.start});
    assign join_prev = (f_reg != HEAD_NODE) &&
        (({2'b0, fd_reg.start} + {1'b0, fd_reg.units}) == {2'b0, h_reg});

    always_comb
    begin
        state_next = state_reg;   pur_next = pur_reg;
        fit_next = fit_reg;       rove_next = rove_reg;    coal_next = coal_reg;
        head_next = head_reg;     rover_next = rover_reg;  top_next = top_reg;
        need_next = need_reg;     grow_next = grow_reg;    start_next = start_reg;
        cur_next = cur_reg;       cnt_next = cnt_reg;      found_next = found_reg;
        best_next = best_reg;     pick_next = pick_reg;    pdat_next = pdat_reg;
        p_next = p_reg;           pd_next = pd_reg;        target_next = target_reg;
        s_next = s_reg;           h_next = h_reg;          bu_next = bu_reg;
        f_next = f_reg;           fd_next = fd_reg;        nx_next = nx_reg;
        nxd_next = nxd_reg;       res_next = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next = rsp_reg;
        mem_re = 1'b0;            mem_raddr = cur_reg[SLOT_W-1:0];
        mem_we = 1'b0;            mem_waddr = p_reg[SLOT_W-1:0];
        mem_wdata = pd_reg;
        slot_ctrl = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIT_POLICY:  fit_next  = cfg_data;
                CFG_SEARCH_ROVE: rove_next = cfg_data[0];
                CFG_COALESCING:  coal_next = cfg_data[0];
                default: ;
            endcase
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    res_next = '0;
                    if (req.action == ACT_ALLOC)
                    begin
                        if (req.request_bytes == '0)
                        begin
                            res_next.status = ST_BAD;
                            state_next = S_FIN;
                        end
                        else if (req_need > HEAP_UNITS)
                        begin
                            res_next.status = ST_NOSPACE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            need_next  = req_need;
                            start_next = rove_reg ? rover_reg : HEAD_NODE;
                            cur_next   = rove_reg ? rover_reg : HEAD_NODE;
                            cnt_next   = '0;
                            found_next = 1'b0;
                            best_next  = '0;
                            state_next = S_A_RD;
                        end
                    end
                    else if (req_free_bad)
                    begin
                        res_next.status = ST_BAD;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        h_next  = req.block_address - 16'd1;
                        bu_next = req.block_units;
                        if (coal_reg)
                        begin
                            f_next     = HEAD_NODE;
                            nx_next    = head_reg;
                            cnt_next   = '0;
                            state_next = S_C_RD;
                        end
                        else
                        begin
                            p_next     = rover_reg;
                            pur_next   = PUR_FREE;
                            state_next = S_N_RD;
                        end
                    end
                end
            end

            S_A_RD:
            begin
                mem_re = 1'b1;
                mem_raddr = cur_reg[SLOT_W-1:0];
                state_next = S_A_EV;
            end

            S_A_EV:
            begin
                if (take)
                begin
                    pick_next  = cur_reg;
                    pdat_next  = mem_rdata;
                    best_next  = walk_u;
                    found_next = 1'b1;
                end
                if ((!is_best && !is_worst && take) ||
                    (is_best && (take ? walk_u == need_reg
                                      : (found_reg && best_reg == need_reg))) ||
                    (walk_nxt == start_reg) || (cnt_reg == WALK_LIMIT))
                begin
                    state_next = S_A_DEC;
                end
                else
                begin
                    cur_next   = walk_nxt;
                    cnt_next   = cnt_reg + 7'd1;
                    state_next = S_A_RD;
                end
            end

            S_A_DEC:
            begin
                if (found_reg && pdat_reg.units >= need_reg)
                begin
                    if (pdat_reg.units > need_reg)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = pick_reg[SLOT_W-1:0];
                        mem_wdata.start = pdat_reg.start + need_reg[ADDR_W-1:0];
                        mem_wdata.units = pdat_reg.units - need_reg;
                        mem_wdata.link  = pdat_reg.link;
                        rover_next = pick_reg;
                        res_next.status = ST_OK;
                        res_next.granted_address = pdat_reg.start + 16'd1;
                        res_next.granted_units = need_reg;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        target_next = pick_reg;
                        p_next      = HEAD_NODE;
                        cnt_next    = '0;
                        pur_next    = PUR_EXACT;
                        state_next  = S_P_RD;
                    end
                end
                else if (!grow_fits)
                begin
                    res_next.status = ST_NOSPACE;
                    state_next = S_FIN;
                end
                else
                begin
                    grow_next = grow_w;
                    pur_next  = PUR_GROW;
                    if (coal_reg)
                    begin
                        target_next = HEAD_NODE;
                        p_next      = HEAD_NODE;
                        cnt_next    = '0;
                        state_next  = S_P_RD;
                    end
                    else
                    begin
                        p_next     = start_reg;
                        state_next = S_N_RD;
                    end
                end
            end

            S_P_RD:
            begin
                mem_re = 1'b1;
                mem_raddr = p_reg[SLOT_W-1:0];
                state_next = S_P_EV;
            end

            S_P_EV:
            begin
                if (pev_next == target_reg)
                begin
                    pd_next = mem_rdata;
                    state_next = S_DISP;
                end
                else if (cnt_reg == WALK_LIMIT)
                begin
                    p_next = HEAD_NODE;
                    state_next = S_DISP;
                end
                else
                begin
                    p_next = pev_next;
                    cnt_next = cnt_reg + 7'd1;
                    state_next = S_P_RD;
                end
            end

            S_N_RD:
            begin
                mem_re = 1'b1;
                mem_raddr = p_reg[SLOT_W-1:0];
                state_next = S_N_EV;
            end

            S_N_EV:
            begin
                pd_next = mem_rdata;
                state_next = S_DISP;
            end

            S_DISP:
            begin
                case (pur_reg)
                    PUR_EXACT:
                    begin
                        if (p_reg == HEAD_NODE)
                        begin
                            head_next = pdat_reg.link;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_waddr = p_reg[SLOT_W-1:0];
                            mem_wdata = pd_reg;
                            mem_wdata.link = pdat_reg.link;
                        end
                        slot_ctrl.clr = 1'b1;
                        slot_ctrl.clr_idx = pick_reg[SLOT_W-1:0];
                        rover_next = p_reg;
                        res_next.status = ST_OK;
                        res_next.granted_address = pdat_reg.start + 16'd1;
                        res_next.granted_units = need_reg;
                        state_next = S_FIN;
                    end
                    PUR_GROW:
                    begin
                        if (grow_reg > need_reg && !slot_stat.any)
                        begin
                            res_next.status = ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            res_next.status = ST_OK;
                            res_next.granted_address = top_reg[ADDR_W-1:0] + 16'd1;
                            res_next.granted_units = need_reg;
                            top_next = top_reg + grow_reg;
                            if (grow_reg > need_reg)
                            begin
                                mem_we = 1'b1;
                                mem_waddr = slot_stat.idx;
                                mem_wdata.start = top_reg[ADDR_W-1:0] + need_reg[ADDR_W-1:0];
                                mem_wdata.units = grow_reg - need_reg;
                                mem_wdata.link  = p_link;
                                slot_ctrl.set = 1'b1;
                                slot_ctrl.set_idx = slot_stat.idx;
                                s_next = slot_stat.idx;
                                rover_next = {1'b0, slot_stat.idx};
                                state_next = S_LINK;
                            end
                            else
                            begin
                                rover_next = p_reg;
                                state_next = S_FIN;
                            end
                        end
                    end
                    default:
                    begin
                        if (!slot_stat.any)
                        begin
                            res_next.status = ST_FULL;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            mem_we = 1'b1;
                            mem_waddr = slot_stat.idx;
                            mem_wdata.start = h_reg;
                            mem_wdata.units = bu_reg;
                            mem_wdata.link  = p_link;
                            slot_ctrl.set = 1'b1;
                            slot_ctrl.set_idx = slot_stat.idx;
                            s_next = slot_stat.idx;
                            rover_next = p_link;
                            res_next.status = ST_OK;
                            state_next = S_LINK;
                        end
                    end
                endcase
            end

            S_LINK:
            begin
                if (p_reg == HEAD_NODE)
                begin
                    head_next = {1'b0, s_reg};
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_waddr = p_reg[SLOT_W-1:0];
                    mem_wdata = pd_reg;
                    mem_wdata.link = {1'b0, s_reg};
                end
                state_next = S_FIN;
            end

            S_C_RD:
            begin
                if (nx_reg == HEAD_NODE)
                begin
                    state_next = S_C_DEC;
                end
                else
                begin
                    mem_re = 1'b1;
                    mem_raddr = nx_reg[SLOT_W-1:0];
                    state_next = S_C_EV;
                end
            end

            S_C_EV:
            begin
                if (mem_rdata.start >= h_reg || cnt_reg == WALK_LIMIT)
                begin
                    nxd_next = mem_rdata;
                    state_next = S_C_DEC;
                end
                else
                begin
                    f_next   = nx_reg;
                    fd_next  = mem_rdata;
                    nx_next  = mem_rdata.link;
                    cnt_next = cnt_reg + 7'd1;
                    state_next = S_C_RD;
                end
            end

            S_C_DEC:
            begin
                state_next = S_FIN;
                res_next.status = ST_OK;
                if (join_prev)
                begin
                    mem_we = 1'b1;
                    mem_waddr = f_reg[SLOT_W-1:0];
                    mem_wdata.start = fd_reg.start;
                    mem_wdata.units = fd_reg.units + bu_reg +
                                      (join_next ? nxd_reg.units : '0);
                    mem_wdata.link  = join_next ? nxd_reg.link : fd_reg.link;
                    slot_ctrl.clr = join_next;
                    slot_ctrl.clr_idx = nx_reg[SLOT_W-1:0];
                    rover_next = f_reg;
                end
                else if (join_next)
                begin
                    mem_we = 1'b1;
                    mem_waddr = nx_reg[SLOT_W-1:0];
                    mem_wdata.start = h_reg;
                    mem_wdata.units = nxd_reg.units + bu_reg;
                    mem_wdata.link  = nxd_reg.link;
                    rover_next = f_reg;
                end
                else if (!slot_stat.any)
                begin
                    res_next.status = ST_FULL;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_waddr = slot_stat.idx;
                    mem_wdata.start = h_reg;
                    mem_wdata.units = bu_reg;
                    mem_wdata.link  = nx_reg;
                    slot_ctrl.set = 1'b1;
                    slot_ctrl.set_idx = slot_stat.idx;
                    s_next  = slot_stat.idx;
                    p_next  = f_reg;
                    pd_next = fd_reg;
                    rover_next = f_reg;
                    state_next = S_LINK;
                end
            end

            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next = res_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;   pur_reg <= PUR_EXACT;
            fit_reg <= FIT_FIRST;  rove_reg <= 1'b0;       coal_reg <= 1'b0;
            head_reg <= HEAD_NODE; rover_reg <= HEAD_NODE; top_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; pur_reg <= pur_next;
            fit_reg <= fit_next;     rove_reg <= rove_next;   coal_reg <= coal_next;
            head_reg <= head_next;   rover_reg <= rover_next; top_reg <= top_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg <= need_next;     grow_reg <= grow_next;   start_reg <= start_next;
        cur_reg <= cur_next;       cnt_reg <= cnt_next;     found_reg <= found_next;
        best_reg <= best_next;     pick_reg <= pick_next;   pdat_reg <= pdat_next;
        p_reg <= p_next;           pd_reg <= pd_next;       target_reg <= target_next;
        s_reg <= s_next;           h_reg <= h_next;         bu_reg <= bu_next;
        f_reg <= f_next;           fd_reg <= fd_next;       nx_reg <= nx_next;
        nxd_reg <= nxd_next;       res_reg <= res_next;     rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= HEAP_UNITS)
        else $error("heap top passed the heap size");

    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("segment memory read and written in one cycle");

    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish step");

endmodule

// ===== tb/flha_checker.sv =====
// ----------------------------------------------------------------------------
// flha_checker: result predictor and scoreboard for the heap allocator.
// Mirrors the free-segment list, rover and heap top, predicts one result per
// accepted request item and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module flha_checker
    import flha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    input  logic       req_stall,
    input  req_item_t  req,
    input  logic       rsp_valid,
    input  logic       rsp_stall,
    input  rsp_item_t  rsp,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [1:0] cfg_data,
    output int         fail_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned HEAD  = 64;
    localparam int unsigned NONE  = 65;
    localparam int unsigned HEAP  = 65536;
    localparam int unsigned PAGE  = 256;

    int unsigned seg_base [FREE_SLOTS];
    int unsigned seg_len  [FREE_SLOTS];
    int unsigned seg_next [FREE_SLOTS];
    bit          slot_busy[FREE_SLOTS];
    int unsigned chain_head;
    int unsigned rover;
    int unsigned heap_top_u;
    logic [1:0]  fit_mode;
    logic        rover_search;
    logic        merge_on;

    rsp_item_t   expected_rsp[$];

    function automatic int unsigned next_of(int unsigned n);
        int unsigned v;
        v = (n >= HEAD) ? chain_head : seg_next[n];
        return (v > HEAD) ? HEAD : v;
    endfunction

    function automatic void link_after(int unsigned n, int unsigned v);
        if (n >= HEAD)
            chain_head = v;
        else
            seg_next[n] = v;
    endfunction

    function automatic int unsigned len_of(int unsigned n);
        return (n >= HEAD) ? 0 : seg_len[n];
    endfunction

    function automatic int unsigned idle_slot();
        for (int i = 0; i < FREE_SLOTS; i++)
            if (!slot_busy[i])
                return i;
        return HEAD;
    endfunction

    function automatic int unsigned pred_node(int unsigned t);
        int unsigned p;
        p = HEAD;
        for (int k = 0; k <= FREE_SLOTS; k++)
        begin
            if (next_of(p) == t)
                return p;
            p = next_of(p);
        end
        return HEAD;
    endfunction

    function automatic rsp_item_t grant(logic [1:0] st, int unsigned a, int unsigned u);
        rsp_item_t r;
        r.status = st;
        r.granted_address = a[ADDR_W-1:0];
        r.granted_units = u[UNITS_W-1:0];
        return r;
    endfunction

    function automatic rsp_item_t predict_alloc(int unsigned bytes);
        int unsigned need, grow, start, cur, pick, best, prev, base, total, s, u;
        if (bytes == 0)
            return grant(ST_BAD, 0, 0);
        need = (bytes + 15) / 16 + 1;
        if (need > HEAP)
            return grant(ST_NOSPACE, 0, 0);
        start = rover_search ? rover : HEAD;
        if (start > HEAD)
            start = HEAD;
        cur = start;
        pick = NONE;
        best = 0;
        for (int k = 0; k <= FREE_SLOTS; k++)
        begin
            u = len_of(cur);
            if (fit_mode == FIT_BEST)
            begin
                if (u >= need && (pick == NONE || u < best))
                begin
                    pick = cur;
                    best = u;
                end
                if (pick != NONE && best == need)
                    break;
            end
            else if (fit_mode == FIT_WORST)
            begin
                if (u > best)
                begin
                    pick = cur;
                    best = u;
                end
            end
            else if (u >= need)
            begin
                pick = cur;
                break;
            end
            cur = next_of(cur);
            if (cur == start)
                break;
        end
        if (pick != NONE && len_of(pick) < need)
            pick = NONE;

        if (pick != NONE && pick < HEAD)
        begin
            prev = pred_node(pick);
            base = seg_base[pick];
            total = seg_len[pick];
            if (total > need)
            begin
                seg_base[pick] = base + need;
                seg_len[pick] = total - need;
                rover = pick;
            end
            else
            begin
                link_after(prev, next_of(pick));
                slot_busy[pick] = 0;
                rover = prev;
            end
            return grant(ST_OK, base + 1, need);
        end

        // Miss: grow the heap by whole pages.
        grow = ((need + PAGE - 1) / PAGE) * PAGE;
        if (grow > HEAP - heap_top_u)
            return grant(ST_NOSPACE, 0, 0);
        base = heap_top_u;
        prev = merge_on ? pred_node(HEAD) : start;
        if (grow > need)
        begin
            s = idle_slot();
            if (s >= HEAD)
                return grant(ST_FULL, 0, 0);
            slot_busy[s] = 1;
            seg_base[s] = base + need;
            seg_len[s] = grow - need;
            seg_next[s] = next_of(prev);
            link_after(prev, s);
            rover = s;
        end
        else
            rover = prev;
        heap_top_u = base + grow;
        return grant(ST_OK, base + 1, need);
    endfunction

    function automatic rsp_item_t predict_free(int unsigned addr, int unsigned units);
        int unsigned h, f, nx, s, r;
        bit join_next, join_prev;
        if (addr == 0 || units == 0 || addr - 1 + units > heap_top_u)
            return grant(ST_BAD, 0, 0);
        h = addr - 1;
        if (!merge_on)
        begin
            r = (rover > HEAD) ? HEAD : rover;
            s = idle_slot();
            if (s >= HEAD)
                return grant(ST_FULL, 0, 0);
            slot_busy[s] = 1;
            seg_base[s] = h;
            seg_len[s] = units;
            seg_next[s] = next_of(r);
            link_after(r, s);
            rover = seg_next[s];
            return grant(ST_OK, 0, 0);
        end
        // Address-ordered insert: find the last segment that starts below h.
        f = HEAD;
        for (int k = 0; k <= FREE_SLOTS; k++)
        begin
            nx = next_of(f);
            if (nx == HEAD || seg_base[nx] >= h)
                break;
            f = nx;
        end
        nx = next_of(f);
        join_next = (nx < HEAD) && (h + units == seg_base[nx]);
        join_prev = (f < HEAD) && (seg_base[f] + seg_len[f] == h);
        if (join_prev)
        begin
            seg_len[f] += units;
            if (join_next)
            begin
                seg_len[f] += seg_len[nx];
                seg_next[f] = next_of(nx);
                slot_busy[nx] = 0;
            end
        end
        else if (join_next)
        begin
            seg_base[nx] = h;
            seg_len[nx] += units;
        end
        else
        begin
            s = idle_slot();
            if (s >= HEAD)
                return grant(ST_FULL, 0, 0);
            slot_busy[s] = 1;
            seg_base[s] = h;
            seg_len[s] = units;
            seg_next[s] = nx;
            link_after(f, s);
        end
        rover = f;
        return grant(ST_OK, 0, 0);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FREE_SLOTS; i++)
                slot_busy[i] = 0;
            chain_head = HEAD;
            rover = HEAD;
            heap_top_u = 0;
            fit_mode = FIT_FIRST;
            rover_search = 0;
            merge_on = 0;
            expected_rsp.delete();
            fail_count = 0;
            pending_count = 0;
        end
        else
        begin
            rsp_item_t want;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected result item", 1, 0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", rsp.status, want.status);
                    if (rsp.granted_address !== want.granted_address)
                        report_mismatch("granted_address", rsp.granted_address,
                                        want.granted_address);
                    if (rsp.granted_units !== want.granted_units)
                        report_mismatch("granted_units", rsp.granted_units,
                                        want.granted_units);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_FIT_POLICY)
                    fit_mode = cfg_data;
                else if (cfg_index == CFG_SEARCH_ROVE)
                    rover_search = cfg_data[0];
                else if (cfg_index == CFG_COALESCING)
                    merge_on = cfg_data[0];
            end
            if (req_valid && !req_stall)
            begin
                if (req.action == ACT_ALLOC)
                    expected_rsp.push_back(predict_alloc(req.request_bytes));
                else
                    expected_rsp.push_back(predict_free(req.block_address,
                                                        req.block_units));
            end
            pending_count = expected_rsp.size();
        end
    end

endmodule

// ===== tb/tb_free_list_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_free_list_heap_allocator: stimulus and verdict for the heap allocator.
// Runs directed corner items and then random alloc/free traffic under all
// fit policies, search starts and coalescing modes, with random idling on
// both channels. Checking is done by flha_checker.
// ----------------------------------------------------------------------------
module tb_free_list_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;
    import flha_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_ITEMS = 122;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    req_item_t  req;
    logic       rsp_valid;
    logic       rsp_stall;
    rsp_item_t  rsp;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending_count;

    // Blocks granted and not yet freed, as {address, units}.
    int unsigned live_addr[$];
    int unsigned live_units[$];
    logic        issued_action[$];
    bit          quiet;
    int          idle_cycles = 0;

    free_list_heap_allocator dut (.*);

    flha_checker u_checker (.*);

    initial
    begin
        clk = 0;
    end

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 4);
    endfunction

    // Result-side stalls and tracking of granted blocks.
    always @(posedge clk or negedge rst_n)
    begin
        int hold;
        if (!rst_n)
        begin
            rsp_stall <= 1'b1;
            hold = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                issued_action.push_back(req.action);
            if (rsp_valid && !rsp_stall)
            begin
                if (issued_action.size() != 0 && issued_action.pop_front() == ACT_ALLOC
                    && rsp.status == ST_OK)
                begin
                    live_addr.push_back(rsp.granted_address);
                    live_units.push_back(rsp.granted_units);
                end
                hold = draw_wait();
                rsp_stall <= (hold != 0);
            end
            else if (hold > 0)
            begin
                hold--;
                rsp_stall <= (hold != 0);
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(logic act, int unsigned bytes, int unsigned addr, int unsigned units);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.action <= act;
        req.request_bytes <= bytes[BYTES_W-1:0];
        req.block_address <= addr[ADDR_W-1:0];
        req.block_units <= units[UNITS_W-1:0];
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(logic [1:0] fit, logic from_rover, logic merge);
        cfg_we <= 1'b1;
        cfg_index <= CFG_FIT_POLICY;
        cfg_data <= fit;
        @(posedge clk);
        cfg_index <= CFG_SEARCH_ROVE;
        cfg_data <= {1'b0, from_rover};
        @(posedge clk);
        cfg_index <= CFG_COALESCING;
        cfg_data <= {1'b0, merge};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic free_live();
        int k;
        int unsigned a, u;
        // Grants still in flight are not in the list yet.
        if (live_addr.size() == 0)
            return;
        k = $urandom_range(0, live_addr.size() - 1);
        a = live_addr[k];
        u = live_units[k];
        live_addr.delete(k);
        live_units.delete(k);
        send(ACT_FREE, $urandom, a, u);
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35 && live_addr.size() != 0)
            free_live();
        else if (r < 45)
            send(ACT_FREE, $urandom, $urandom_range(0, 65535), $urandom_range(0, 65536));
        else if (r < 50)
            send(ACT_ALLOC, $urandom_range(0, 1048575), $urandom, $urandom);
        else if (r < 60)
            send(ACT_ALLOC, $urandom_range(1, 16) * 16, $urandom, $urandom);
        else
            send(ACT_ALLOC, $urandom_range(1, 3000), $urandom, $urandom);
    endtask

    initial
    begin
        logic [1:0] fits[8]  = '{FIT_FIRST, FIT_BEST, FIT_WORST, 2'd3,
                                 FIT_BEST, FIT_WORST, FIT_FIRST, FIT_WORST};
        bit         roves[8] = '{0, 0, 1, 1, 1, 0, 1, 1};
        bit         merges[8] = '{0, 1, 0, 1, 0, 1, 1, 1};
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_FIT_POLICY;
        cfg_data = 2'd0;
        quiet = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under reset settings.
        send(ACT_ALLOC, 0, 0, 0);
        send(ACT_ALLOC, 1048575, 0, 0);
        send(ACT_ALLOC, 1048560, 0, 0);
        send(ACT_FREE, 0, 0, 5);
        send(ACT_FREE, 0, 5, 0);
        send(ACT_FREE, 0, 65535, 65536);
        send(ACT_ALLOC, 1, 0, 0);
        send(ACT_ALLOC, 4080, 0, 0);
        send(ACT_ALLOC, 4096, 0, 0);
        send(ACT_ALLOC, 16, 0, 0);
        send(ACT_ALLOC, 4064, 0, 0);
        send(ACT_ALLOC, 32, 0, 0);
        drain();
        repeat (4) free_live();
        drain();
        configure(FIT_BEST, 1'b0, 1'b1);
        send(ACT_ALLOC, 48, 0, 0);
        send(ACT_ALLOC, 200, 0, 0);
        repeat (4) free_live();
        send(ACT_ALLOC, 100, 0, 0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            configure(fits[p], roves[p], merges[p]);
            quiet = (p == 3);
            repeat (PHASE_ITEMS) random_item();
            drain();
        end
        quiet = 0;
        configure(FIT_FIRST, 1'b0, 1'b0);
        while (live_addr.size() != 0)
            free_live();
        drain();
        repeat (300) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
